>>> hdl/pca_pkg.sv
package pca_pkg;

  // Field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned PIN_W   = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CHAN_W  = 5;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MASK_W  = 16;

  // Defaults
  localparam int unsigned      DEF_CHANNELS  = 16;
  localparam logic [MASK_W-1:0] RESERVED_RST = 16'h0303;

  // Pin codes: 255 marks a free owner entry, 254 and up never own a channel
  localparam logic [PIN_W-1:0] FREE_PIN    = 8'd255;
  localparam logic [PIN_W-1:0] NO_OWN_PIN  = 8'd254;

  // Duty thresholds
  localparam logic [VALUE_W-1:0] DUTY_OFF  = 16'd0;
  localparam logic [VALUE_W-1:0] DUTY_FULL = 16'd255;
  localparam logic [VALUE_W-1:0] DUTY_MID  = 16'd127;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_DUTY       = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TONE_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TONE_STOP  = 2'd2;

  // Write kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DUTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TONE = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic               drive_digital;
    logic               digital_level;
    logic               do_setup;
    logic               do_attach;
    logic               do_detach;
    logic [KIND_W-1:0]  write_kind;
    logic [VALUE_W-1:0] write_value;
  } pca_result_t;

endpackage

>>> hdl/pca_if.sv
interface pca_req_if;
  logic                         valid;
  logic                         ready;
  logic [pca_pkg::FUNC_W-1:0]   func;
  logic [pca_pkg::PIN_W-1:0]    pin;
  logic [pca_pkg::VALUE_W-1:0]  value;

  modport source (output valid, func, pin, value, input ready);
  modport sink   (input valid, func, pin, value, output ready);
endinterface

interface pca_res_if;
  logic                         valid;
  logic                         ready;
  logic [pca_pkg::CHAN_W-1:0]   channel;
  logic                         drive_digital;
  logic                         digital_level;
  logic                         do_setup;
  logic                         do_attach;
  logic                         do_detach;
  logic [pca_pkg::KIND_W-1:0]   write_kind;
  logic [pca_pkg::VALUE_W-1:0]  write_value;

  modport source (output valid, channel, drive_digital, digital_level, do_setup,
                  do_attach, do_detach, write_kind, write_value, input ready);
  modport sink   (input valid, channel, drive_digital, digital_level, do_setup,
                  do_attach, do_detach, write_kind, write_value, output ready);
endinterface

interface pca_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pca_pkg::MASK_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/pca_owner_tbl.sv
// Owner table: one pin per channel in a memory with registered read.
// Entries never written read as the free code.
module pca_owner_tbl #(
  parameter int unsigned CHANNELS = pca_pkg::DEF_CHANNELS,
  parameter int unsigned IW       = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [IW-1:0]              rd_addr,
  output logic [pca_pkg::PIN_W-1:0]  rd_owner,
  input  logic                       wr_en,
  input  logic [IW-1:0]              wr_addr,
  input  logic [pca_pkg::PIN_W-1:0]  wr_pin
);
  import pca_pkg::*;

  logic [PIN_W-1:0]    mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [PIN_W-1:0]    rd_data_r;
  logic                rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_pin;
    end
  end

  // Mark written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign rd_owner = rd_vld_r ? rd_data_r : FREE_PIN;

endmodule

>>> hdl/pwm_channel_allocator.sv
// Channel   | Dir | Handshake       | Payload
// in_req    | in  | valid / ready   | func, pin, value
// out_res   | out | valid / ready   | channel, drive/attach flags, write_kind, write_value
// cfg_wr    | in  | valid / ready   | data -> reserved_mask
//
// A request scans the owner table: one entry is read and compared per cycle, then
// the FIN state settles the result. A pin found early ends the scan sooner; a
// request that skips the scan goes from IDLE straight to FIN.
// Reset (rst_n low at a clock edge) frees all owners, clears active flags
// and loads the reserved mask with 0x0303. No clearing pass is needed.
// A result waits in the output register; a new request is taken meanwhile,
// and a finished request holds only if the previous result is still unread.
module pwm_channel_allocator #(
  parameter int unsigned CHANNELS = pca_pkg::DEF_CHANNELS
) (
  input  logic          clk,
  input  logic          rst_n,
  pca_req_if.sink       in_req,
  pca_res_if.source     out_res,
  pca_cfg_if.sink       cfg_wr
);
  import pca_pkg::*;

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW = $clog2(CHANNELS + 1);
  localparam logic [CW-1:0] CH_NONE = CW'(CHANNELS);
  localparam logic [CW-1:0] CH_LAST = CW'(CHANNELS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [MASK_W-1:0]   mask_r;
  logic [FUNC_W-1:0]   func_r;
  logic [PIN_W-1:0]    pin_r;
  logic [VALUE_W-1:0]  value_r;
  logic [CW-1:0]       addr_r, addr_nxt;
  logic                rdv_r, rdv_nxt;
  logic [IW-1:0]       cmp_r, cmp_nxt;
  logic                ff_r, ff_nxt;
  logic [IW-1:0]       free_r, free_nxt;
  logic [CW-1:0]       ch_r, ch_nxt;
  logic                chok_r, chok_nxt;
  logic                claim_r, claim_nxt;
  logic [CHANNELS-1:0] act_r;
  logic [PIN_W-1:0]    owner;
  logic [MASK_W-1:0]   rsv_sh;
  logic                rsv;
  logic                take;
  logic                ld_en;
  logic                act_cur, act_new;
  logic [IW-1:0]       ch_idx;
  pca_result_t         res_nxt, res_r;
  logic                out_vld_r;

  // Reserved-mask register
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= RESERVED_RST;
    end else if (cfg_wr.valid) begin
      mask_r <= cfg_wr.data;
    end
  end

  assign in_req.ready = (state_r == ST_IDLE);
  assign take         = in_req.valid && in_req.ready;
  assign ch_idx       = ch_r[IW-1:0];

  pca_owner_tbl #(.CHANNELS(CHANNELS), .IW(IW)) u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (addr_r[IW-1:0]),
    .rd_owner (owner),
    .wr_en    (ld_en && claim_r),
    .wr_addr  (ch_idx),
    .wr_pin   (pin_r)
  );

  // Channels at 16 and above shift out of the mask and are never reserved
  assign rsv_sh = mask_r >> cmp_r;
  assign rsv    = rsv_sh[0];

  // Sequencer: start, scan one entry per cycle, settle
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    rdv_nxt   = 1'b0;
    cmp_nxt   = cmp_r;
    ff_nxt    = ff_r;
    free_nxt  = free_r;
    ch_nxt    = ch_r;
    chok_nxt  = chok_r;
    claim_nxt = claim_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          addr_nxt  = '0;
          ff_nxt    = 1'b0;
          ch_nxt    = CH_NONE;
          chok_nxt  = 1'b0;
          claim_nxt = 1'b0;
          if (in_req.func inside {FUNC_DUTY, FUNC_TONE_START, FUNC_TONE_STOP}
              && in_req.pin < NO_OWN_PIN) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read
        if (addr_r < CH_NONE) begin
          rdv_nxt  = 1'b1;
          cmp_nxt  = addr_r[IW-1:0];
          addr_nxt = addr_r + CW'(1);
        end
        // compare the entry read last cycle
        if (rdv_r) begin
          if (owner == pin_r) begin
            ch_nxt    = CW'(cmp_r);
            chok_nxt  = 1'b1;
            rdv_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            if (owner == FREE_PIN && !rsv && !ff_r) begin
              ff_nxt   = 1'b1;
              free_nxt = cmp_r;
            end
            if (CW'(cmp_r) == CH_LAST) begin
              ch_nxt    = ff_nxt ? CW'(free_nxt) : CH_NONE;
              chok_nxt  = ff_nxt;
              claim_nxt = ff_nxt;
              rdv_nxt   = 1'b0;
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_FIN: begin
        if (ld_en) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdv_r   <= 1'b0;
      claim_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      claim_r <= claim_nxt;
    end
  end

  // Hold request and scan bookkeeping
  always_ff @(posedge clk) begin
    if (take) begin
      func_r  <= in_req.func;
      pin_r   <= in_req.pin;
      value_r <= in_req.value;
    end
    addr_r <= addr_nxt;
    cmp_r  <= cmp_nxt;
    ff_r   <= ff_nxt;
    free_r <= free_nxt;
    ch_r   <= ch_nxt;
    chok_r <= chok_nxt;
  end

  // Decide the driver actions
  assign act_cur = chok_r && act_r[ch_idx];
  always_comb begin
    res_nxt         = '0;
    res_nxt.channel = CHAN_W'(ch_r);
    act_new         = act_cur;
    if (!chok_r) begin
      if (func_r == FUNC_DUTY) begin
        res_nxt.drive_digital = 1'b1;
        res_nxt.digital_level = (value_r > DUTY_MID);
      end
    end else begin
      case (func_r)
        FUNC_DUTY: begin
          if (value_r == DUTY_OFF || value_r == DUTY_FULL) begin
            res_nxt.drive_digital = 1'b1;
            res_nxt.digital_level = (value_r == DUTY_FULL);
            res_nxt.do_detach     = act_cur;
            act_new               = 1'b0;
          end else begin
            res_nxt.write_kind  = KIND_DUTY;
            res_nxt.write_value = value_r;
            res_nxt.do_setup    = !act_cur;
            res_nxt.do_attach   = !act_cur;
            act_new             = 1'b1;
          end
        end
        FUNC_TONE_START: begin
          res_nxt.write_kind  = KIND_TONE;
          res_nxt.write_value = value_r;
          res_nxt.do_setup    = !act_cur;
          res_nxt.do_attach   = !act_cur;
          act_new             = 1'b1;
        end
        FUNC_TONE_STOP: begin
          res_nxt.write_kind = KIND_TONE;
          res_nxt.do_setup   = !act_cur;
          res_nxt.do_attach  = !act_cur;
          res_nxt.do_detach  = act_cur;
          act_new            = !act_cur;
        end
        default: begin
          res_nxt.channel = CHAN_W'(CH_NONE);
        end
      endcase
    end
  end

  // Load the output register once the previous result is taken
  assign ld_en = (state_r == ST_FIN) && (!out_vld_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (ld_en && chok_r) begin
        act_r[ch_idx] <= act_new;
      end
      if (ld_en) begin
        out_vld_r <= 1'b1;
      end else if (out_res.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid         = out_vld_r;
  assign out_res.channel       = res_r.channel;
  assign out_res.drive_digital = res_r.drive_digital;
  assign out_res.digital_level = res_r.digital_level;
  assign out_res.do_setup      = res_r.do_setup;
  assign out_res.do_attach     = res_r.do_attach;
  assign out_res.do_detach     = res_r.do_detach;
  assign out_res.write_kind    = res_r.write_kind;
  assign out_res.write_value   = res_r.write_value;

  // A taken request blocks the input for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_req.ready)
    else $error("request taken while busy");

  // An attach leaves the channel active
  a_attach_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_en && chok_r && res_nxt.do_attach) |=> act_r[$past(ch_idx)])
    else $error("attached channel not active");

  // Attach and detach never come together
  a_attach_xor_detach: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.do_attach && res_r.do_detach))
    else $error("attach and detach in one result");

  // A digital level never comes with a channel write
  a_digital_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.drive_digital && res_r.write_kind != KIND_NONE))
    else $error("digital drive with channel write");

  // A claim only ever takes a real channel
  a_claim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_en && claim_r) |-> (chok_r && ch_r < CH_NONE))
    else $error("claim outside channel range");

endmodule
